@@ rtl/csp_pkg.sv @@
// ----------------------------------------------------------------------------
// Cubic spline evaluator package
// Shared widths, action codes, fixed-point helpers and the control structs
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package csp_pkg;

  localparam int MAX_POINTS  = 64;
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int ADDR_W      = $clog2(MAX_POINTS);
  localparam int COUNT_W     = 7;
  localparam int ACTION_W    = 3;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int TN_W        = FRAC_BITS + COUNT_W;
  localparam int POW_W       = FRAC_BITS + 1;
  localparam int WGT_W       = FRAC_BITS + 5;
  localparam int PROD_W      = COORD_WIDTH + WGT_W;
  localparam int ACC_W       = PROD_W + 2;
  localparam int SHIFT_W     = ACC_W - (FRAC_BITS + 1);
  localparam int IDX_W       = COUNT_W + 1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR   = 3'd0,
    ACT_APPEND  = 3'd1,
    ACT_EVAL    = 3'd2,
    ACT_ADVANCE = 3'd3,
    ACT_SETPROG = 3'd4
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLOSED_LOOP  = 2'd0,
    CFG_BASIS_SELECT = 2'd1
  } cfg_index_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_item;
    logic       update;
    logic       tn_en;
    logic       sq_en;
    logic       cu_en;
    logic       wgt_en;
    logic       rd_en;
    logic       mul_en;
    logic       acc_en;
    logic       fin_en;
    logic       out_load;
    logic [1:0] k;
  } csp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [ACTION_W-1:0] act;
    logic                empty;
  } csp_stat_t;

  // Product of two Q.FRAC_BITS values rounded half up to FRAC_BITS bits.
  function automatic logic [POW_W-1:0] rnd_mul(input logic [POW_W-1:0] a,
                                               input logic [POW_W-1:0] b);
    logic [2*POW_W-1:0] prod;
    prod = a * b + ((2*POW_W)'(1) << (FRAC_BITS - 1));
    return prod[FRAC_BITS +: POW_W];
  endfunction

endpackage

@@ rtl/csp_in_if.sv @@
// ----------------------------------------------------------------------------
// Request input channel
// Valid/ready channel carrying one request of the spline evaluator.
// ----------------------------------------------------------------------------
interface csp_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [csp_pkg::ACTION_W-1:0]           action;
  logic signed [csp_pkg::COORD_WIDTH-1:0] coord_x;
  logic signed [csp_pkg::COORD_WIDTH-1:0] coord_y;
  logic signed [csp_pkg::COORD_WIDTH-1:0] coord_z;
  logic [csp_pkg::FRAC_BITS-1:0]          fraction;

  modport source(output valid, action, coord_x, coord_y, coord_z, fraction, input ready);
  modport sink(input valid, action, coord_x, coord_y, coord_z, fraction, output ready);
endinterface

@@ rtl/csp_out_if.sv @@
// ----------------------------------------------------------------------------
// Result output channel
// Valid/ready channel carrying one result of the spline evaluator.
// ----------------------------------------------------------------------------
interface csp_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [csp_pkg::COORD_WIDTH-1:0] out_x;
  logic signed [csp_pkg::COORD_WIDTH-1:0] out_y;
  logic signed [csp_pkg::COORD_WIDTH-1:0] out_z;
  logic [csp_pkg::STATUS_W-1:0]           status;
  logic [csp_pkg::COUNT_W-1:0]            point_count;
  logic [csp_pkg::FRAC_BITS-1:0]          progress_now;

  modport source(output valid, out_x, out_y, out_z, status, point_count, progress_now,
                 input ready);
  modport sink(input valid, out_x, out_y, out_z, status, point_count, progress_now,
               output ready);
endinterface

@@ rtl/csp_cfg_if.sv @@
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface csp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [csp_pkg::CFG_IDX_W-1:0] index;
  logic                          data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/cubic_spline_point_evaluator.sv @@
// ----------------------------------------------------------------------------
// Cubic spline point evaluator
// Holds up to 64 control points and evaluates a Catmull-Rom or Bezier curve.
// ----------------------------------------------------------------------------
// One request is in flight at a time. Clear, append, set-progress and unused
// action codes, and evaluate or advance on an empty table, go from the update
// straight to the result hand-off; other evaluate or advance requests pass
// through the update, t*N, the squares, the cubes and the basis weights, then
// four rounds of fetch, multiply and accumulate through the single-port point
// table, then round and saturate. A new request is accepted while the previous
// result waits in the output register; configuration writes are always taken.
module cubic_spline_point_evaluator (
  input logic  clk,
  input logic  rst,
  csp_in_if.sink    in_ch,
  csp_out_if.source out_ch,
  csp_cfg_if.sink   cfg_ch
);

  csp_pkg::csp_cmd_t  cmd;
  csp_pkg::csp_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  // Sequencer.
  csp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Storage and arithmetic.
  csp_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_ch.valid),
    .cfg_index    (cfg_ch.index),
    .cfg_data     (cfg_ch.data),
    .action       (in_ch.action),
    .coord_x      (in_ch.coord_x),
    .coord_y      (in_ch.coord_y),
    .coord_z      (in_ch.coord_z),
    .fraction     (in_ch.fraction),
    .out_x        (out_ch.out_x),
    .out_y        (out_ch.out_y),
    .out_z        (out_ch.out_z),
    .status       (out_ch.status),
    .point_count  (out_ch.point_count),
    .progress_now (out_ch.progress_now)
  );

`ifndef SYNTH
  // A result is never loaded over one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("result register overwritten");

  // An accepted request makes the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request accepted while busy");

  // The reported point count never exceeds the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.point_count <= csp_pkg::COUNT_W'(csp_pkg::MAX_POINTS)))
    else $error("point count beyond table size");
`endif

endmodule

@@ rtl/csp_ctrl.sv @@
// ----------------------------------------------------------------------------
// Spline evaluator controller
// One-hot sequencer that steps each request through update and result hand-off;
// non-empty evaluate/advance adds weights, four fetch/MAC rounds and rounding.
// ----------------------------------------------------------------------------
module csp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  csp_pkg::csp_stat_t stat,
  output csp_pkg::csp_cmd_t  cmd
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_UPD  = 11'b000_0000_0010,
    S_TN   = 11'b000_0000_0100,
    S_SQ   = 11'b000_0000_1000,
    S_CU   = 11'b000_0001_0000,
    S_WGT  = 11'b000_0010_0000,
    S_RD   = 11'b000_0100_0000,
    S_MUL  = 11'b000_1000_0000,
    S_ACC  = 11'b001_0000_0000,
    S_FIN  = 11'b010_0000_0000,
    S_DONE = 11'b100_0000_0000
  } state_t;

  state_t     state, state_next;
  logic [1:0] k, k_next;
  logic       is_eval;
  logic       slot_free;

  assign in_ready  = (state == S_IDLE);
  assign is_eval   = (stat.act == csp_pkg::ACT_EVAL) || (stat.act == csp_pkg::ACT_ADVANCE);
  assign slot_free = !out_valid || out_ready;

  // Next-state and command decode.
  always_comb begin
    state_next = state;
    k_next     = k;
    cmd        = '0;
    cmd.k      = k;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_next = (is_eval && !stat.empty) ? S_TN : S_DONE;
      end
      S_TN: begin
        cmd.tn_en  = 1'b1;
        state_next = S_SQ;
      end
      S_SQ: begin
        cmd.sq_en  = 1'b1;
        state_next = S_CU;
      end
      S_CU: begin
        cmd.cu_en  = 1'b1;
        state_next = S_WGT;
      end
      S_WGT: begin
        cmd.wgt_en = 1'b1;
        k_next     = 2'd0;
        state_next = S_RD;
      end
      S_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc_en = 1'b1;
        k_next     = k + 2'd1;
        state_next = (k == 2'd3) ? S_FIN : S_RD;
      end
      S_FIN: begin
        cmd.fin_en = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State, round counter and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      k         <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      k     <= k_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/csp_dpath.sv @@
// ----------------------------------------------------------------------------
// Spline evaluator datapath
// Point tables, count and progress state, basis weight pipeline, the
// multiply-accumulate unit and the output register.
// ----------------------------------------------------------------------------
module csp_dpath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  csp_pkg::csp_cmd_t                      cmd,
  output csp_pkg::csp_stat_t                     stat,
  input  logic                                   cfg_we,
  input  logic [csp_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic                                   cfg_data,
  input  logic [csp_pkg::ACTION_W-1:0]           action,
  input  logic signed [csp_pkg::COORD_WIDTH-1:0] coord_x,
  input  logic signed [csp_pkg::COORD_WIDTH-1:0] coord_y,
  input  logic signed [csp_pkg::COORD_WIDTH-1:0] coord_z,
  input  logic [csp_pkg::FRAC_BITS-1:0]          fraction,
  output logic signed [csp_pkg::COORD_WIDTH-1:0] out_x,
  output logic signed [csp_pkg::COORD_WIDTH-1:0] out_y,
  output logic signed [csp_pkg::COORD_WIDTH-1:0] out_z,
  output logic [csp_pkg::STATUS_W-1:0]           status,
  output logic [csp_pkg::COUNT_W-1:0]            point_count,
  output logic [csp_pkg::FRAC_BITS-1:0]          progress_now
);

  localparam int CW = csp_pkg::COORD_WIDTH;
  localparam int FB = csp_pkg::FRAC_BITS;
  localparam int PW = csp_pkg::POW_W;
  localparam int WW = csp_pkg::WGT_W;

  // Point tables, written on append and read one row per fetch.
  logic [CW-1:0] mem_x [csp_pkg::MAX_POINTS];
  logic [CW-1:0] mem_y [csp_pkg::MAX_POINTS];
  logic [CW-1:0] mem_z [csp_pkg::MAX_POINTS];
  logic signed [CW-1:0] rd_x, rd_y, rd_z;

  logic closed_loop, basis_select;
  logic [csp_pkg::COUNT_W-1:0] count;
  logic [FB-1:0]               progress;
  logic [csp_pkg::ACTION_W-1:0] act;
  logic signed [CW-1:0] cx, cy, cz;
  logic [FB-1:0]        frac;
  logic [csp_pkg::STATUS_W-1:0] status_r;
  logic full;

  logic [csp_pkg::TN_W-1:0] tn;
  logic [FB-1:0]            t_sel;
  logic [csp_pkg::ADDR_W-1:0] p;
  logic [PW-1:0] s, u, s2, u2, s3, u3, u2s, us2;
  logic [PW-1:0] s_in, u_in;
  logic signed [WW-1:0] w [4];
  logic signed [WW-1:0] w_next [4];
  logic signed [WW-1:0] w_k;
  logic signed [csp_pkg::PROD_W-1:0] prod_x, prod_y, prod_z;
  logic signed [csp_pkg::ACC_W-1:0]  acc_x, acc_y, acc_z;
  logic signed [CW-1:0] res_x, res_y, res_z;

  logic signed [csp_pkg::IDX_W-1:0] raw_idx, n_s, fix_idx;

  assign full = (count == csp_pkg::COUNT_W'(csp_pkg::MAX_POINTS));
  assign stat.act   = act;
  assign stat.empty = (count == '0);

  // Rounded arithmetic shift and saturation of one accumulator.
  function automatic logic signed [CW-1:0] round_sat(input logic signed [csp_pkg::ACC_W-1:0] a);
    logic signed [csp_pkg::ACC_W-1:0]   sum;
    logic signed [csp_pkg::SHIFT_W-1:0] sh;
    logic signed [CW-1:0]               r;
    sum = a + (csp_pkg::ACC_W'(1) <<< FB);
    sh  = csp_pkg::SHIFT_W'(sum >>> (FB + 1));
    // In range only when every bit above the result's sign bit copies it.
    if (!sh[csp_pkg::SHIFT_W-1] && (sh[csp_pkg::SHIFT_W-2:CW-1] != '0)) begin
      r = {1'b0, {(CW-1){1'b1}}};
    end else if (sh[csp_pkg::SHIFT_W-1] && (sh[csp_pkg::SHIFT_W-2:CW-1] != '1)) begin
      r = {1'b1, {(CW-1){1'b0}}};
    end else begin
      r = sh[CW-1:0];
    end
    return r;
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      closed_loop  <= 1'b0;
      basis_select <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        csp_pkg::CFG_CLOSED_LOOP:  closed_loop  <= cfg_data;
        csp_pkg::CFG_BASIS_SELECT: basis_select <= cfg_data;
        default: ;
      endcase
    end
  end

  // Request latch.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      act  <= action;
      cx   <= coord_x;
      cy   <= coord_y;
      cz   <= coord_z;
      frac <= fraction;
    end
  end

  // Count, progress and request status.
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      progress <= '0;
      status_r <= csp_pkg::ST_OK;
    end else if (cmd.update) begin
      status_r <= csp_pkg::ST_OK;
      case (act)
        csp_pkg::ACT_CLEAR: count <= '0;
        csp_pkg::ACT_APPEND: begin
          if (full) begin
            status_r <= csp_pkg::ST_FULL;
          end else begin
            count <= count + 1'b1;
          end
        end
        csp_pkg::ACT_EVAL: begin
          if (count == '0) status_r <= csp_pkg::ST_EMPTY;
        end
        csp_pkg::ACT_ADVANCE: begin
          progress <= progress + frac;
          if (count == '0) status_r <= csp_pkg::ST_EMPTY;
        end
        csp_pkg::ACT_SETPROG: progress <= frac;
        default: ;
      endcase
    end
  end

  // Table write on append and registered read of one row.
  always_ff @(posedge clk) begin
    if (cmd.update && act == csp_pkg::ACT_APPEND && !full) begin
      mem_x[count[csp_pkg::ADDR_W-1:0]] <= cx;
      mem_y[count[csp_pkg::ADDR_W-1:0]] <= cy;
      mem_z[count[csp_pkg::ADDR_W-1:0]] <= cz;
    end
    if (cmd.rd_en) begin
      rd_x <= mem_x[fix_idx[csp_pkg::ADDR_W-1:0]];
      rd_y <= mem_y[fix_idx[csp_pkg::ADDR_W-1:0]];
      rd_z <= mem_z[fix_idx[csp_pkg::ADDR_W-1:0]];
    end
  end

  // Point index p-1+k, wrapped or clamped to the table.
  always_comb begin
    n_s     = csp_pkg::IDX_W'(count);
    raw_idx = csp_pkg::IDX_W'(p) + csp_pkg::IDX_W'(cmd.k) - csp_pkg::IDX_W'(1);
    if (closed_loop) begin
      if (count == csp_pkg::COUNT_W'(1)) fix_idx = '0;
      else if (raw_idx < 0)              fix_idx = raw_idx + n_s;
      else if (raw_idx >= n_s)           fix_idx = raw_idx - n_s;
      else                               fix_idx = raw_idx;
    end else begin
      if (raw_idx < 0)                                  fix_idx = '0;
      else if (raw_idx > n_s - csp_pkg::IDX_W'(1))      fix_idx = n_s - csp_pkg::IDX_W'(1);
      else                                              fix_idx = raw_idx;
    end
  end

  // Segment position, then the powers of s and u.
  assign t_sel = (act == csp_pkg::ACT_ADVANCE) ? progress : frac;
  assign s_in  = PW'(tn[FB-1:0]);
  assign u_in  = (PW'(1) << FB) - s_in;

  always_ff @(posedge clk) begin
    if (cmd.tn_en) tn <= t_sel * count;
    if (cmd.sq_en) begin
      p  <= tn[FB +: csp_pkg::ADDR_W];
      s  <= s_in;
      u  <= u_in;
      s2 <= csp_pkg::rnd_mul(s_in, s_in);
      u2 <= csp_pkg::rnd_mul(u_in, u_in);
    end
    if (cmd.cu_en) begin
      s3  <= csp_pkg::rnd_mul(s2, s);
      u3  <= csp_pkg::rnd_mul(u2, u);
      u2s <= csp_pkg::rnd_mul(u2, s);
      us2 <= csp_pkg::rnd_mul(u, s2);
    end
  end

  // Doubled basis weights.
  always_comb begin
    logic signed [WW-1:0] a1, a2, a3;
    a1 = WW'(s);
    a2 = WW'(s2);
    a3 = WW'(s3);
    if (basis_select) begin
      w_next[0] = WW'(u3) <<< 1;
      w_next[1] = (WW'(u2s) <<< 2) + (WW'(u2s) <<< 1);
      w_next[2] = (WW'(us2) <<< 2) + (WW'(us2) <<< 1);
      w_next[3] = a3 <<< 1;
    end else begin
      w_next[0] = -a3 + (a2 <<< 1) - a1;
      w_next[1] = (a3 <<< 1) + a3 - (a2 <<< 2) - a2 + (WW'(1) <<< (FB + 1));
      w_next[2] = -(a3 <<< 1) - a3 + (a2 <<< 2) + a1;
      w_next[3] = a3 - a2;
    end
  end

  assign w_k = w[cmd.k];

  // Weights, multiply-accumulate and rounded result.
  always_ff @(posedge clk) begin
    if (cmd.wgt_en) begin
      w     <= w_next;
      acc_x <= '0;
      acc_y <= '0;
      acc_z <= '0;
    end
    if (cmd.mul_en) begin
      prod_x <= rd_x * w_k;
      prod_y <= rd_y * w_k;
      prod_z <= rd_z * w_k;
    end
    if (cmd.acc_en) begin
      acc_x <= acc_x + csp_pkg::ACC_W'(prod_x);
      acc_y <= acc_y + csp_pkg::ACC_W'(prod_y);
      acc_z <= acc_z + csp_pkg::ACC_W'(prod_z);
    end
    if (cmd.load_item) begin
      res_x <= '0;
      res_y <= '0;
      res_z <= '0;
    end else if (cmd.fin_en) begin
      res_x <= round_sat(acc_x);
      res_y <= round_sat(acc_y);
      res_z <= round_sat(acc_z);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_x        <= res_x;
      out_y        <= res_y;
      out_z        <= res_z;
      status       <= status_r;
      point_count  <= count;
      progress_now <= progress;
    end
  end

endmodule

@@ tb/csp_spline_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spline evaluator checker
// Watches the request, result and configuration channels. It keeps its own
// copy of the point table, progress and settings, predicts the result of every
// accepted request and compares each accepted result with the oldest one.
// ----------------------------------------------------------------------------
module csp_spline_checker
  import csp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  csp_in_if         in_ch,
  csp_out_if        out_ch,
  csp_cfg_if        cfg_ch,
  output int        fail_count,
  output int        pending
);

  typedef struct {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
    logic [STATUS_W-1:0]           status;
    logic [COUNT_W-1:0]            count;
    logic [FRAC_BITS-1:0]          progress;
  } spline_result_t;

  logic signed [COORD_WIDTH-1:0] pts_x [MAX_POINTS];
  logic signed [COORD_WIDTH-1:0] pts_y [MAX_POINTS];
  logic signed [COORD_WIDTH-1:0] pts_z [MAX_POINTS];
  int unsigned                   held;
  logic [FRAC_BITS-1:0]          progress;
  logic                          closed;
  logic                          bezier;
  spline_result_t                expected_results [$];

  // Product of two fractions, rounded half up to the fraction width.
  function automatic longint round_mul(longint a, longint b);
    return (a * b + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  // Weighted sum of four points, divided by twice the unit and saturated.
  function automatic logic signed [COORD_WIDTH-1:0] blend(
      input logic signed [COORD_WIDTH-1:0] p0, p1, p2, p3, input longint w[4]);
    longint sum;
    longint lim;
    lim = longint'(1) << (COORD_WIDTH - 1);
    sum = longint'(p0) * w[0] + longint'(p1) * w[1] + longint'(p2) * w[2]
        + longint'(p3) * w[3];
    sum = (sum + (longint'(1) << FRAC_BITS)) >>> (FRAC_BITS + 1);
    if (sum > lim - 1) sum = lim - 1;
    if (sum < -lim) sum = -lim;
    return sum[COORD_WIDTH-1:0];
  endfunction

  // Curve point at fraction t of the whole curve; the table is not empty.
  function automatic void eval_curve(input logic [FRAC_BITS-1:0] t,
                                     inout spline_result_t r);
    longint tn, seg, s, u, s2, s3, u2, u3, i;
    longint w[4];
    int     idx[4];
    tn  = longint'(t) * held;
    seg = tn >>> FRAC_BITS;
    s   = tn & ((longint'(1) << FRAC_BITS) - 1);
    for (int k = 0; k < 4; k++) begin
      i = seg - 1 + k;
      if (closed) begin
        if (i < 0) i += held;
        i = i % held;
      end else if (i < 0) begin
        i = 0;
      end else if (i > held - 1) begin
        i = held - 1;
      end
      idx[k] = int'(i);
    end
    s2 = round_mul(s, s);
    s3 = round_mul(s2, s);
    if (bezier) begin
      u  = (longint'(1) << FRAC_BITS) - s;
      u2 = round_mul(u, u);
      u3 = round_mul(u2, u);
      w[0] = 2 * u3;
      w[1] = 6 * round_mul(u2, s);
      w[2] = 6 * round_mul(u, s2);
      w[3] = 2 * s3;
    end else begin
      w[0] = -s3 + 2 * s2 - s;
      w[1] = 3 * s3 - 5 * s2 + 2 * (longint'(1) << FRAC_BITS);
      w[2] = -3 * s3 + 4 * s2 + s;
      w[3] = s3 - s2;
    end
    r.x = blend(pts_x[idx[0]], pts_x[idx[1]], pts_x[idx[2]], pts_x[idx[3]], w);
    r.y = blend(pts_y[idx[0]], pts_y[idx[1]], pts_y[idx[2]], pts_y[idx[3]], w);
    r.z = blend(pts_z[idx[0]], pts_z[idx[1]], pts_z[idx[2]], pts_z[idx[3]], w);
  endfunction

  // Applies one request to the shadow state and returns the expected result.
  function automatic spline_result_t apply_request();
    spline_result_t       r;
    logic [FRAC_BITS-1:0] t;
    r = '{x: '0, y: '0, z: '0, status: ST_OK, count: '0, progress: '0};
    t = in_ch.fraction;
    case (in_ch.action)
      ACT_CLEAR: held = 0;
      ACT_APPEND: begin
        if (held < MAX_POINTS) begin
          pts_x[held] = in_ch.coord_x;
          pts_y[held] = in_ch.coord_y;
          pts_z[held] = in_ch.coord_z;
          held++;
        end else begin
          r.status = ST_FULL;
        end
      end
      ACT_EVAL, ACT_ADVANCE: begin
        if (in_ch.action == ACT_ADVANCE) begin
          progress = progress + in_ch.fraction;
          t = progress;
        end
        if (held == 0) r.status = ST_EMPTY;
        else eval_curve(t, r);
      end
      ACT_SETPROG: progress = in_ch.fraction;
      default: ;
    endcase
    r.count    = COUNT_W'(held);
    r.progress = progress;
    return r;
  endfunction

  // Adds a prediction at the tail of the queue.
  function automatic void queue_result(input spline_result_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  always @(posedge clk) begin
    spline_result_t want;
    int             errs;
    errs = 0;
    if (rst) begin
      held       = 0;
      progress   = '0;
      closed     = 1'b0;
      bezier     = 1'b0;
      fail_count <= 0;
      expected_results.delete();
    end else begin
      // Settings take effect for requests accepted in the same cycle as the write or later.
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == CFG_CLOSED_LOOP) closed = cfg_ch.data;
        else if (cfg_ch.index == CFG_BASIS_SELECT) bezier = cfg_ch.data;
      end
      if (in_ch.valid && in_ch.ready) queue_result(apply_request());
      // Compare each result with the oldest prediction.
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result arrived with no request outstanding");
          errs++;
        end else begin
          want = expected_results.pop_front();
          if (out_ch.out_x !== want.x) begin
            $error("out_x: expected %0d, got %0d", want.x, out_ch.out_x);
            errs++;
          end
          if (out_ch.out_y !== want.y) begin
            $error("out_y: expected %0d, got %0d", want.y, out_ch.out_y);
            errs++;
          end
          if (out_ch.out_z !== want.z) begin
            $error("out_z: expected %0d, got %0d", want.z, out_ch.out_z);
            errs++;
          end
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            errs++;
          end
          if (out_ch.point_count !== want.count) begin
            $error("point_count: expected %0d, got %0d", want.count, out_ch.point_count);
            errs++;
          end
          if (out_ch.progress_now !== want.progress) begin
            $error("progress_now: expected %0d, got %0d", want.progress,
                   out_ch.progress_now);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
    pending <= expected_results.size();
  end

endmodule

@@ tb/tb_cubic_spline_point_evaluator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spline evaluator testbench
// Drives directed and random requests under all four curve settings with
// random gaps and result stalls; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_cubic_spline_point_evaluator;
  import csp_pkg::*;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   max_gap;
  int   max_stall;
  logic long_hold;

  csp_in_if  in_ch();
  csp_out_if out_ch();
  csp_cfg_if cfg_ch();

  cubic_spline_point_evaluator dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  csp_spline_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Clock with a 12 ns period.
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Overall time limit.
  initial begin
    #30ms;
    $display("Some tests failed");
    $finish;
  end

  // Result side: random stalls, and one long hold-off when asked.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = $urandom_range(0, max_stall);
      if (long_hold) begin
        stall     = 400;
        long_hold = 1'b0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Sends one request; valid stays high afterwards unless a gap follows.
  task automatic send_request(input logic [ACTION_W-1:0] act,
                              input logic [COORD_WIDTH-1:0] x, y, z,
                              input logic [FRAC_BITS-1:0] frac);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.action   <= act;
    in_ch.coord_x  <= x;
    in_ch.coord_y  <= y;
    in_ch.coord_z  <= z;
    in_ch.fraction <= frac;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Waits for every result, then lets the block's own latency run out.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_setting(input cfg_index_t idx, input logic value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Coordinates: mostly modest values, sometimes full range or the extremes.
  function automatic logic [COORD_WIDTH-1:0] pick_coord();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return {1'b0, {(COORD_WIDTH-1){1'b1}}};
      2:       return {1'b1, {(COORD_WIDTH-1){1'b0}}};
      default: return COORD_WIDTH'($signed($urandom_range(0, 2000000)) - 1000000);
    endcase
  endfunction

  task automatic append_point();
    send_request(ACT_APPEND, pick_coord(), pick_coord(), pick_coord(),
                 FRAC_BITS'($urandom));
  endtask

  task automatic random_request();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) send_request(ACT_CLEAR, $urandom, $urandom, $urandom,
                               FRAC_BITS'($urandom));
    else if (roll < 40) append_point();
    else if (roll < 65) send_request(ACT_EVAL, $urandom, $urandom, $urandom,
                                     FRAC_BITS'($urandom));
    else if (roll < 85) send_request(ACT_ADVANCE, $urandom, $urandom, $urandom,
                                     FRAC_BITS'($urandom_range(0, 4000)));
    else if (roll < 93) send_request(ACT_SETPROG, $urandom, $urandom, $urandom,
                                     FRAC_BITS'($urandom));
    else send_request(ACTION_W'($urandom_range(5, 7)), $urandom, $urandom, $urandom,
                      FRAC_BITS'($urandom));
  endtask

  initial begin
    rst          = 1'b1;
    max_gap      = 0;
    max_stall    = 0;
    long_hold    = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.action = ACT_CLEAR;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    in_ch.coord_z = '0;
    in_ch.fraction = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_CLOSED_LOOP;
    cfg_ch.data  = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, extremes, unused codes, progress wrap.
    max_gap   = 3;
    max_stall = 3;
    send_request(ACT_EVAL, '0, '0, '0, 16'h8000);
    send_request(ACT_ADVANCE, '0, '0, '0, 16'hFFFF);
    send_request(ACT_APPEND, 32'h7FFFFFFF, 32'h80000000, 32'h0, 16'h0);
    send_request(ACT_EVAL, '0, '0, '0, 16'h0);
    send_request(ACT_APPEND, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
    send_request(ACT_APPEND, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h00010000, 16'h1234);
    send_request(ACT_APPEND, 32'h80000000, 32'h80000000, 32'hFFFF0000, 16'h0);
    send_request(ACT_EVAL, '0, '0, '0, 16'h0);
    send_request(ACT_EVAL, '0, '0, '0, 16'hFFFF);
    send_request(ACT_EVAL, '0, '0, '0, 16'h5555);
    send_request(ACT_SETPROG, '0, '0, '0, 16'hFFFF);
    send_request(ACT_ADVANCE, '0, '0, '0, 16'h0002);
    send_request(3'd5, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
    send_request(3'd6, '0, '0, '0, 16'h0);
    send_request(3'd7, '0, '0, '0, 16'h0);
    send_request(ACT_CLEAR, '0, '0, '0, 16'h0);
    send_request(ACT_EVAL, '0, '0, '0, 16'h4000);
    send_request(ACT_ADVANCE, '0, '0, '0, 16'h0100);
    drain();

    // Random phases across all settings; the first also fills the table.
    for (int phase = 0; phase < 8; phase++) begin
      write_setting(CFG_CLOSED_LOOP, phase[0]);
      write_setting(CFG_BASIS_SELECT, phase[1]);
      max_gap   = (phase % 3 == 2) ? 0 : 18;
      max_stall = (phase % 3 == 1) ? 0 : 18;
      send_request(ACT_CLEAR, '0, '0, '0, '0);
      if (phase == 0) begin
        repeat (66) append_point();
        send_request(ACT_EVAL, '0, '0, '0, 16'hFFFF);
        send_request(ACT_EVAL, '0, '0, '0, 16'h0);
      end
      // Receiver stalls for a long stretch while requests keep coming.
      if (phase == 3) begin
        max_gap   = 0;
        long_hold = 1'b1;
      end
      repeat (190) random_request();
      // Sender waits for every outstanding result before going on.
      drain();
    end

    drain();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/csp_pkg.sv
rtl/csp_in_if.sv
rtl/csp_out_if.sv
rtl/csp_cfg_if.sv
rtl/csp_ctrl.sv
rtl/csp_dpath.sv
rtl/cubic_spline_point_evaluator.sv
tb/csp_spline_checker.sv
tb/tb_cubic_spline_point_evaluator.sv
